FILE: rtl/bfsa_pkg.sv
// Package for the best-fit segment allocator: operation, status and state codes, flag bits and limits.
// No dependencies.
package bfsa_pkg;

  typedef enum logic [2:0] {
    KIND_INIT  = 3'd0,
    KIND_ALLOC = 3'd1,
    KIND_FREE  = 3'd2,
    KIND_MARK  = 3'd3,
    KIND_PURGE = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTREADY = 3'd1,
    ST_ZERO     = 3'd2,
    ST_NOFIT    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_BADPOOL  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_INIT,
    S_SCAN,
    S_BEST_RD,
    S_BEST_WR,
    S_PAD,
    S_TAIL,
    S_FRAG_RD,
    S_FRAG,
    S_DIV,
    S_OUT
  } state_t;

  localparam logic [2:0]  F_USED = 3'b001;
  localparam logic [2:0]  F_FREE = 3'b010;
  localparam logic [2:0]  F_PURG = 3'b100;
  localparam logic [31:0] SENTINEL_BYTES = 32'd4096;
  localparam logic [32:0] POOL_LIMIT = 33'h0_8000_0000;
  localparam logic [30:0] RECLAIM_MAX = 31'h7FFF_FFFF;

endpackage

FILE: rtl/best_fit_segment_allocator.sv
// Best-fit aligned segment allocator, top level.
// Depends on bfsa_pkg; holds the flag and bounds memories.
//
//  channel | dir | tdata (low bit first)                              | tuser
//  s_axis  | in  | kind[2:0], request_size, alignment, address, pad   | -
//  m_axis  | out | status[2:0], address_out, reclaimed_bytes[30:0],   | -
//          |     | fragmentation_percent[6:0], ready_res, pad          |
//  cfg     | in  | pool_size written when cfg_we is high              | -
//
// Sequence: alloc/free/mark/purge scan the table once (one memory read per
// cycle), then, when the pool is ready, a second scan counts used/free entries
// and a 7-step divide forms the percentage, unless no entry is used. Alloc
// adds a read and a write of the best entry plus up to two scans to place
// padding and tail. Init clears all flags in place of the first scan; errors
// skip it.
// Reset clears control only; the flag memory is cleared by the init sweep and
// guarded by pool_ready. The result register holds while m_axis_tready is low;
// the next transaction is still taken and waits in the output state.
module best_fit_segment_allocator #(
  parameter int SEGMENTS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // kind[2:0], request_size[34:3], alignment[66:35], address[98:67]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], address_out[34:3], reclaimed_bytes[65:35],
  // fragmentation_percent[72:66], ready_res[73]
  output logic [79:0]  m_axis_tdata
);

  localparam int IW = $clog2(SEGMENTS);
  localparam int CW = IW + 1;

  // Memories: flags and bounds (start low, size high).
  logic [2:0]  flags_mem [SEGMENTS];
  logic [63:0] bounds_mem [SEGMENTS];

  logic [IW-1:0] rd_addr;
  logic [2:0]    rd_flags;
  logic [63:0]   rd_bounds;
  logic          f_we, b_we;
  logic [IW-1:0] wr_addr;
  logic [2:0]    wr_flags;
  logic [63:0]   wr_bounds;

  always_ff @(posedge clk) begin
    if (f_we) flags_mem[wr_addr] <= wr_flags;
    if (b_we) bounds_mem[wr_addr] <= wr_bounds;
    rd_flags  <= flags_mem[rd_addr];
    rd_bounds <= bounds_mem[rd_addr];
  end

  // Control and working registers.
  bfsa_pkg::state_t state, state_next;
  logic [31:0] pool_size;
  logic        pool_ready, pool_ready_next;
  logic [2:0]  kind;
  logic [31:0] req, align, addr;
  logic [2:0]  status, status_next;
  logic [31:0] aout, aout_next;
  logic [31:0] back, back_next;          // sum saturates into 31 bits
  logic [CW-1:0] idx, idx_next;          // issue index
  logic [CW-1:0] cnt, cnt_next;          // index of data in rd_*
  logic          rvalid, rvalid_next;
  logic          found, found_next;
  logic [IW-1:0] best, best_next;
  logic [32:0]   min_slack, min_slack_next;
  logic [31:0]   pad_s, pad_l, tail_s, tail_l;
  logic [31:0]   pad_s_next, pad_l_next, tail_s_next, tail_l_next;
  logic          pad_done, pad_done_next;
  logic [CW-1:0] used_cnt, used_cnt_next, free_cnt, free_cnt_next;
  logic [CW+6:0] num, num_next;
  logic [6:0]    quo, quo_next;
  logic [2:0]    dstep, dstep_next;
  logic [79:0]   out_data, out_data_next;
  logic          out_valid;
  logic          out_load;               // result register takes a new result

  // Per-entry arithmetic on the entry being read.
  logic [32:0] s64, l64, am1, ca, pad, need, waste;
  logic        fit;
  always_comb begin
    s64   = {1'b0, rd_bounds[31:0]};
    l64   = {1'b0, rd_bounds[63:32]};
    am1   = {1'b0, align} - 33'd1;
    ca    = (s64 + am1) & ~am1;
    pad   = ca - s64;
    need  = pad + {1'b0, req};
    fit   = !(need > l64) && !need[32];
    waste = l64 - need;
  end

  logic [IW+6:0] div_sub;
  logic [CW-1:0] last_idx;
  assign last_idx = CW'(SEGMENTS - 1);
  assign div_sub  = (IW+7)'(used_cnt) << dstep;
  assign out_load = (state == bfsa_pkg::S_OUT) && (!out_valid || m_axis_tready);

  always_comb begin
    state_next      = state;
    pool_ready_next = pool_ready;
    status_next     = status;
    aout_next       = aout;
    back_next       = back;
    idx_next        = idx;
    cnt_next        = cnt;
    rvalid_next     = 1'b0;
    found_next      = found;
    best_next       = best;
    min_slack_next  = min_slack;
    pad_s_next = pad_s; pad_l_next = pad_l;
    tail_s_next = tail_s; tail_l_next = tail_l;
    pad_done_next   = pad_done;
    used_cnt_next   = used_cnt;
    free_cnt_next   = free_cnt;
    num_next        = num;
    quo_next        = quo;
    dstep_next      = dstep;
    out_data_next   = out_data;
    rd_addr   = idx[IW-1:0];
    f_we      = 1'b0;
    b_we      = 1'b0;
    wr_addr   = idx[IW-1:0];
    wr_flags  = '0;
    wr_bounds = '0;

    case (state)
      bfsa_pkg::S_IDLE: begin
        idx_next   = '0;
        found_next = 1'b0;
        back_next  = '0;
        aout_next  = '0;
        status_next = bfsa_pkg::ST_OK;
        if (s_axis_tvalid) begin
          case (s_axis_tdata[2:0])
            bfsa_pkg::KIND_INIT: begin
              if (pool_size == 0 || {1'b0, pool_size} > bfsa_pkg::POOL_LIMIT) begin
                status_next = bfsa_pkg::ST_BADPOOL;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else begin
                state_next = bfsa_pkg::S_CLEAR;
              end
            end
            bfsa_pkg::KIND_ALLOC, bfsa_pkg::KIND_FREE, bfsa_pkg::KIND_PURGE: begin
              if (!pool_ready) begin
                status_next = bfsa_pkg::ST_NOTREADY;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else if (s_axis_tdata[2:0] == bfsa_pkg::KIND_ALLOC
                           && s_axis_tdata[34:3] == 0) begin
                status_next = bfsa_pkg::ST_ZERO;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else if (s_axis_tdata[2:0] == bfsa_pkg::KIND_FREE
                           && s_axis_tdata[98:67] == 0) begin
                status_next = bfsa_pkg::ST_ZERO;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else begin
                state_next = bfsa_pkg::S_SCAN;
              end
            end
            bfsa_pkg::KIND_MARK: begin
              // readiness tested after the zero check; an unready table answers not found
              if (s_axis_tdata[98:67] == 0) begin
                status_next = bfsa_pkg::ST_ZERO;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else if (!pool_ready) begin
                status_next = bfsa_pkg::ST_NOTFOUND;
                state_next  = bfsa_pkg::S_FRAG_RD;
              end else begin
                state_next = bfsa_pkg::S_SCAN;
              end
            end
            default: state_next = bfsa_pkg::S_FRAG_RD;
          endcase
        end
      end

      bfsa_pkg::S_CLEAR: begin
        f_we    = 1'b1;
        wr_addr = idx[IW-1:0];
        idx_next = idx + 1'b1;
        if (idx == last_idx) state_next = bfsa_pkg::S_INIT;
      end

      bfsa_pkg::S_INIT: begin
        if (!pad_done) begin
          f_we = 1'b1; b_we = 1'b1;
          wr_addr  = '0;
          wr_flags = bfsa_pkg::F_USED;
          wr_bounds = {(pool_size > bfsa_pkg::SENTINEL_BYTES) ?
                       bfsa_pkg::SENTINEL_BYTES : pool_size, 32'd0};
          pad_done_next = 1'b1;
          if (!(pool_size > bfsa_pkg::SENTINEL_BYTES)) begin
            pool_ready_next = 1'b1;
            pad_done_next = 1'b0;
            state_next = bfsa_pkg::S_FRAG_RD;
          end
        end else begin
          f_we = 1'b1; b_we = 1'b1;
          wr_addr  = IW'(1);
          wr_flags = bfsa_pkg::F_USED | bfsa_pkg::F_FREE;
          wr_bounds = {pool_size - bfsa_pkg::SENTINEL_BYTES, bfsa_pkg::SENTINEL_BYTES};
          pool_ready_next = 1'b1;
          pad_done_next = 1'b0;
          state_next = bfsa_pkg::S_FRAG_RD;
        end
      end

      bfsa_pkg::S_SCAN: begin
        // issue reads at idx, evaluate data for cnt in the cycle after
        rd_addr = idx[IW-1:0];
        if (idx != CW'(SEGMENTS)) begin
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end
        cnt_next = idx;
        if (rvalid) begin
          case (kind)
            bfsa_pkg::KIND_ALLOC: begin
              if ((rd_flags & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) ==
                  (bfsa_pkg::F_USED | bfsa_pkg::F_FREE) && fit &&
                  (!found || waste < min_slack)) begin
                found_next = 1'b1;
                best_next = cnt[IW-1:0];
                min_slack_next = waste;
              end
            end
            bfsa_pkg::KIND_FREE, bfsa_pkg::KIND_MARK: begin
              if (!found && (rd_flags & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) ==
                  bfsa_pkg::F_USED && rd_bounds[31:0] == addr) begin
                found_next = 1'b1;
                best_next = cnt[IW-1:0];
                f_we = 1'b1;
                wr_addr = cnt[IW-1:0];
                wr_flags = (kind == bfsa_pkg::KIND_FREE) ?
                           (bfsa_pkg::F_USED | bfsa_pkg::F_FREE) :
                           (rd_flags | bfsa_pkg::F_PURG);
              end
            end
            default: begin // purge
              if (rd_flags == (bfsa_pkg::F_USED | bfsa_pkg::F_PURG)) begin
                f_we = 1'b1;
                wr_addr = cnt[IW-1:0];
                wr_flags = bfsa_pkg::F_USED | bfsa_pkg::F_FREE;
                back_next = ({1'b0, back} + {1'b0, rd_bounds[63:32]} >
                             {2'b0, bfsa_pkg::RECLAIM_MAX}) ?
                            {1'b0, bfsa_pkg::RECLAIM_MAX} :
                            back + rd_bounds[63:32];
              end
            end
          endcase
        end
        if (!rvalid && idx == CW'(SEGMENTS)) begin
          idx_next = '0;
          if (kind == bfsa_pkg::KIND_ALLOC) begin
            if (found) state_next = bfsa_pkg::S_BEST_RD;
            else begin
              status_next = bfsa_pkg::ST_NOFIT;
              state_next = bfsa_pkg::S_FRAG_RD;
            end
          end else begin
            if ((kind == bfsa_pkg::KIND_FREE || kind == bfsa_pkg::KIND_MARK) && !found)
              status_next = bfsa_pkg::ST_NOTFOUND;
            state_next = bfsa_pkg::S_FRAG_RD;
          end
        end
      end

      bfsa_pkg::S_BEST_RD: begin
        rd_addr = best;
        state_next = bfsa_pkg::S_BEST_WR;
      end

      bfsa_pkg::S_BEST_WR: begin
        f_we = 1'b1; b_we = 1'b1;
        wr_addr = best;
        wr_flags = bfsa_pkg::F_USED;
        wr_bounds = {req, ca[31:0]};
        aout_next = ca[31:0];
        pad_s_next = rd_bounds[31:0];
        pad_l_next = pad[31:0];
        tail_s_next = ca[31:0] + req;
        tail_l_next = rd_bounds[31:0] + rd_bounds[63:32] - ca[31:0] - req;
        idx_next = '0;
        found_next = 1'b0;
        state_next = bfsa_pkg::S_PAD;
      end

      // Place padding then tail in the first unused slot.
      bfsa_pkg::S_PAD, bfsa_pkg::S_TAIL: begin
        rd_addr = idx[IW-1:0];
        if (idx != CW'(SEGMENTS)) begin
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end
        cnt_next = idx;
        if ((state == bfsa_pkg::S_PAD ? pad_l : tail_l) == 0) begin
          idx_next = '0;
          rvalid_next = 1'b0;
          state_next = (state == bfsa_pkg::S_PAD) ? bfsa_pkg::S_TAIL : bfsa_pkg::S_FRAG_RD;
        end else if (rvalid && !rd_flags[0]) begin
          f_we = 1'b1; b_we = 1'b1;
          wr_addr = cnt[IW-1:0];
          wr_flags = bfsa_pkg::F_USED | bfsa_pkg::F_FREE;
          wr_bounds = (state == bfsa_pkg::S_PAD) ? {pad_l, pad_s} : {tail_l, tail_s};
          idx_next = '0;
          rvalid_next = 1'b0;
          state_next = (state == bfsa_pkg::S_PAD) ? bfsa_pkg::S_TAIL : bfsa_pkg::S_FRAG_RD;
        end else if (!rvalid && idx == CW'(SEGMENTS)) begin
          idx_next = '0;
          state_next = (state == bfsa_pkg::S_PAD) ? bfsa_pkg::S_TAIL : bfsa_pkg::S_FRAG_RD;
        end
      end

      bfsa_pkg::S_FRAG_RD: begin
        idx_next = '0;
        used_cnt_next = '0;
        free_cnt_next = '0;
        state_next = pool_ready_next ? bfsa_pkg::S_FRAG : bfsa_pkg::S_OUT;
        quo_next = '0;
      end

      bfsa_pkg::S_FRAG: begin
        rd_addr = idx[IW-1:0];
        if (idx != CW'(SEGMENTS)) begin
          idx_next = idx + 1'b1;
          rvalid_next = 1'b1;
        end
        if (rvalid && rd_flags[0]) begin
          used_cnt_next = used_cnt + 1'b1;
          if (rd_flags[1]) free_cnt_next = free_cnt + 1'b1;
        end
        if (!rvalid && idx == CW'(SEGMENTS)) begin
          num_next = (CW+7)'(free_cnt) * (CW+7)'(100);
          dstep_next = 3'd6;
          quo_next = '0;
          state_next = (used_cnt == 0) ? bfsa_pkg::S_OUT : bfsa_pkg::S_DIV;
        end
      end

      bfsa_pkg::S_DIV: begin
        // restoring divide, one quotient bit per cycle (quotient <= 100)
        if (num >= (CW+7)'(div_sub)) begin
          num_next = num - (CW+7)'(div_sub);
          quo_next = quo | (7'd1 << dstep);
        end
        dstep_next = dstep - 1'b1;
        if (dstep == 0) state_next = bfsa_pkg::S_OUT;
      end

      bfsa_pkg::S_OUT: begin
        // wait here while the previous result is still held
        if (!out_valid || m_axis_tready) begin
          out_data_next = {6'd0, pool_ready, quo, back[30:0], aout, status};
          state_next = bfsa_pkg::S_IDLE;
        end
      end

      default: state_next = bfsa_pkg::S_IDLE;
    endcase
  end

  assign s_axis_tready = (state == bfsa_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfsa_pkg::S_IDLE;
      pool_ready <= 1'b0;
      pool_size  <= '0;
      out_valid  <= 1'b0;
      rvalid     <= 1'b0;
      pad_done   <= 1'b0;
    end else begin
      state      <= state_next;
      pool_ready <= pool_ready_next;
      rvalid     <= rvalid_next;
      pad_done   <= pad_done_next;
      if (cfg_we) pool_size <= cfg_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind  <= s_axis_tdata[2:0];
      req   <= s_axis_tdata[34:3];
      align <= (s_axis_tdata[66:35] == 0) ? bfsa_pkg::SENTINEL_BYTES : s_axis_tdata[66:35];
      addr  <= s_axis_tdata[98:67];
    end
    status     <= status_next;
    aout       <= aout_next;
    back       <= back_next;
    idx        <= idx_next;
    cnt        <= cnt_next;
    found      <= found_next;
    best       <= best_next;
    min_slack  <= min_slack_next;
    pad_s <= pad_s_next; pad_l <= pad_l_next;
    tail_s <= tail_s_next; tail_l <= tail_l_next;
    used_cnt   <= used_cnt_next;
    free_cnt   <= free_cnt_next;
    num        <= num_next;
    quo        <= quo_next;
    dstep      <= dstep_next;
    out_data   <= out_data_next;
  end

endmodule

FILE: tb/best_fit_segment_allocator_test.sv
// Self-checking testbench for best_fit_segment_allocator: directed corner cases,
// then random allocate/free/mark/purge traffic checked against a segment-table predictor.
// Depends on bfsa_pkg and the RTL top level only.
module best_fit_segment_allocator_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGMENTS = 256;
  // generous bound on one transaction: clear/scan sweeps, two placement sweeps, count, divide
  localparam int DRAIN_CYCLES = 4 * SEGMENTS + 200;

  typedef struct {
    bfsa_pkg::status_t status;
    logic [31:0] addr;
    logic [30:0] reclaimed;
    logic [6:0]  frag;
    logic        ready;
  } response_t;

  // Predicts the allocator response for each accepted transaction.
  class segment_table_model;
    bit [2:0]  flags[SEGMENTS];
    bit [31:0] base[SEGMENTS];
    bit [31:0] size[SEGMENTS];
    bit        pool_ready;
    bit [31:0] pool_bytes;
    response_t expected_responses[$];
    int        mismatches;

    function new();
      foreach (flags[i]) begin
        flags[i] = '0;
        base[i] = '0;
        size[i] = '0;
      end
      pool_ready = 0;
      pool_bytes = '0;
      mismatches = 0;
    endfunction

    function void set_entry(int i, bit [2:0] f, bit [63:0] s, bit [63:0] l);
      flags[i] = f;
      base[i] = s[31:0];
      size[i] = l[31:0];
    endfunction

    // padding/remainder go to the first unused slot; dropped when the table is full
    function void add_free(bit [63:0] s, bit [63:0] l);
      if (l[31:0] == 0) return;
      for (int j = 0; j < SEGMENTS; j++) begin
        if (!flags[j][0]) begin
          set_entry(j, bfsa_pkg::F_USED | bfsa_pkg::F_FREE, s, l);
          return;
        end
      end
    endfunction

    function int find_block(bit [31:0] a);
      for (int i = 0; i < SEGMENTS; i++)
        if ((flags[i] & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) == bfsa_pkg::F_USED &&
            base[i] == a) return i;
      return -1;
    endfunction

    function bit [6:0] frag_percent();
      int used_cnt;
      int free_cnt;
      used_cnt = 0;
      free_cnt = 0;
      if (!pool_ready) return '0;
      for (int i = 0; i < SEGMENTS; i++) begin
        if (flags[i][0]) begin
          used_cnt++;
          if (flags[i][1]) free_cnt++;
        end
      end
      return used_cnt ? 7'((free_cnt * 100) / used_cnt) : 7'd0;
    endfunction

    // random start address of a live (used, not free) block, 0 if none besides sentinel
    function bit [31:0] live_block();
      bit [31:0] q[$];
      for (int i = 0; i < SEGMENTS; i++)
        if ((flags[i] & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) == bfsa_pkg::F_USED)
          q.push_back(base[i]);
      if (q.size() == 0) return '0;
      return q[$urandom_range(q.size() - 1)];
    endfunction

    function void note_request(logic [103:0] d);
      bit [2:0]  kind;
      bit [63:0] req, algn, addr;
      bit [63:0] s, l, ca, waste, min_slack, e, nend;
      bit [63:0] back;
      int        best;
      int        idx;
      response_t r;
      kind = d[2:0];
      req = {32'd0, d[34:3]};
      algn = {32'd0, d[66:35]};
      addr = {32'd0, d[98:67]};
      r.status = bfsa_pkg::ST_OK;
      r.addr = '0;
      back = '0;
      case (kind)
        bfsa_pkg::KIND_INIT: begin
          if (pool_bytes == 0 || {32'd0, pool_bytes} > 64'h8000_0000) begin
            r.status = bfsa_pkg::ST_BADPOOL;
          end else begin
            for (int i = 0; i < SEGMENTS; i++) set_entry(i, '0, 64'd0, 64'd0);
            set_entry(0, bfsa_pkg::F_USED, 64'd0,
                      64'(pool_bytes > bfsa_pkg::SENTINEL_BYTES ?
                          bfsa_pkg::SENTINEL_BYTES : pool_bytes));
            if (pool_bytes > bfsa_pkg::SENTINEL_BYTES)
              add_free(64'(bfsa_pkg::SENTINEL_BYTES),
                       64'(pool_bytes - bfsa_pkg::SENTINEL_BYTES));
            pool_ready = 1;
          end
        end
        bfsa_pkg::KIND_ALLOC: begin
          if (!pool_ready) r.status = bfsa_pkg::ST_NOTREADY;
          else if (req == 0) r.status = bfsa_pkg::ST_ZERO;
          else begin
            best = -1;
            min_slack = '0;
            if (algn == 0) algn = 64'd4096;
            for (int i = 0; i < SEGMENTS; i++) begin
              if ((flags[i] & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) !=
                  (bfsa_pkg::F_USED | bfsa_pkg::F_FREE)) continue;
              s = 64'(base[i]);
              l = 64'(size[i]);
              ca = (s + algn - 1) & ~(algn - 1);
              if (ca - s + req > l) continue;
              waste = l - (ca - s) - req;
              if (best < 0 || waste < min_slack) begin
                best = i;
                min_slack = waste;
              end
            end
            if (best < 0) r.status = bfsa_pkg::ST_NOFIT;
            else begin
              s = 64'(base[best]);
              e = s + 64'(size[best]);
              ca = (s + algn - 1) & ~(algn - 1);
              nend = ca + req;
              set_entry(best, bfsa_pkg::F_USED, ca, req);
              if (ca > s) add_free(s, ca - s);
              if (nend < e) add_free(nend, e - nend);
              r.addr = ca[31:0];
            end
          end
        end
        bfsa_pkg::KIND_FREE: begin
          if (!pool_ready) r.status = bfsa_pkg::ST_NOTREADY;
          else if (addr == 0) r.status = bfsa_pkg::ST_ZERO;
          else begin
            idx = find_block(addr[31:0]);
            if (idx < 0) r.status = bfsa_pkg::ST_NOTFOUND;
            else flags[idx] = bfsa_pkg::F_USED | bfsa_pkg::F_FREE;
          end
        end
        bfsa_pkg::KIND_MARK: begin
          // no readiness test here: an empty table simply finds nothing
          if (addr == 0) r.status = bfsa_pkg::ST_ZERO;
          else begin
            idx = find_block(addr[31:0]);
            if (idx < 0) r.status = bfsa_pkg::ST_NOTFOUND;
            else flags[idx] = flags[idx] | bfsa_pkg::F_PURG;
          end
        end
        bfsa_pkg::KIND_PURGE: begin
          if (!pool_ready) r.status = bfsa_pkg::ST_NOTREADY;
          else begin
            for (int i = 0; i < SEGMENTS; i++) begin
              if ((flags[i] & (bfsa_pkg::F_USED | bfsa_pkg::F_FREE | bfsa_pkg::F_PURG)) ==
                  (bfsa_pkg::F_USED | bfsa_pkg::F_PURG)) begin
                back += 64'(size[i]);
                flags[i] = bfsa_pkg::F_USED | bfsa_pkg::F_FREE;
              end
            end
            if (back > {33'd0, bfsa_pkg::RECLAIM_MAX}) back = {33'd0, bfsa_pkg::RECLAIM_MAX};
          end
        end
        default: ;  // unknown kinds change nothing
      endcase
      r.reclaimed = back[30:0];
      r.frag = frag_percent();
      r.ready = pool_ready;
      expected_responses.push_back(r);
    endfunction

    function void check_response(logic [79:0] d);
      response_t got, want;
      got.status = bfsa_pkg::status_t'(d[2:0]);
      got.addr = d[34:3];
      got.reclaimed = d[65:35];
      got.frag = d[72:66];
      got.ready = d[73];
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: response with nothing outstanding: %h", $realtime, d);
        return;
      end
      want = expected_responses.pop_front();
      if (got.status !== want.status || got.addr !== want.addr ||
          got.reclaimed !== want.reclaimed || got.frag !== want.frag ||
          got.ready !== want.ready) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp st=%0d addr=%h recl=%h frag=%0d rdy=%0d got st=%0d addr=%h recl=%h frag=%0d rdy=%0d",
                   $realtime, want.status, want.addr, want.reclaimed, want.frag, want.ready,
                   d[2:0], got.addr, got.reclaimed, got.frag, got.ready);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;

  segment_table_model table_model = new();

  int tx_idle_pct = 0;   // chance per cycle that the sender holds off
  int rx_stall_pct = 0;  // chance per cycle that the receiver stalls
  int hold_request = 0;  // long receiver hold-off, picked up by the receiver process
  int hold_left = 0;

  best_fit_segment_allocator #(.SEGMENTS(SEGMENTS)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, plus a long counted hold-off on request so the block backs up.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Result checker: a transaction moves at an edge with tvalid and tready both high.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) table_model.check_response(m_axis_tdata);
  end

  // Offer one request; the predictor is updated at the accepting edge.
  task automatic send_request(bit [2:0] kind, bit [31:0] req, bit [31:0] algn, bit [31:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, addr, algn, req, kind};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    table_model.note_request(s_axis_tdata);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (table_model.expected_responses.size() != 0);
  endtask

  // pool_size only changes while the block is idle
  task automatic write_pool_size(bit [31:0] v);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    table_model.pool_bytes = v;
    cfg_we <= 1'b0;
  endtask

  function automatic bit [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(1, 4096);
    if (r < 85) return $urandom_range(1, 32'h0010_0000);
    if (r < 95) return $urandom;
    return 32'd1;
  endfunction

  function automatic bit [31:0] pick_alignment();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 32'd1 << $urandom_range(0, 31);
    if (r < 60) return 32'd0;
    if (r < 80) return 32'd1 << $urandom_range(0, 12);
    if (r < 90) return $urandom;  // usually not a power of two
    return 32'd1;
  endfunction

  // One random transaction; alloc_pct sets how hard the table is pushed toward full.
  task automatic random_request(int alloc_pct);
    int r;
    r = $urandom_range(99);
    if (r < alloc_pct)
      send_request(bfsa_pkg::KIND_ALLOC, pick_size(), pick_alignment(), $urandom);
    else if (r < alloc_pct + (100 - alloc_pct) * 4 / 10)
      send_request(bfsa_pkg::KIND_FREE, $urandom, $urandom, table_model.live_block());
    else if (r < alloc_pct + (100 - alloc_pct) * 7 / 10)
      send_request(bfsa_pkg::KIND_MARK, $urandom, $urandom, table_model.live_block());
    else if (r < 95)
      send_request(bfsa_pkg::KIND_PURGE, $urandom, $urandom, $urandom);
    else if (r < 97)
      send_request(bfsa_pkg::KIND_FREE, $urandom, $urandom, $urandom);  // stray address
    else
      send_request(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);  // noise
  endtask

  bit [31:0] pools[5] = '{32'h8000_0000, 32'h0010_0000, 32'd4097, 32'd8192, 32'h0001_0000};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Before any init: alloc, free and purge answer not ready; mark answers zero or not found; unknown kinds answer ok.
    send_request(bfsa_pkg::KIND_ALLOC, 32'd16, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_FREE, 32'd0, 32'd0, 32'h1000);
    send_request(bfsa_pkg::KIND_PURGE, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_MARK, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_MARK, 32'd0, 32'd0, 32'h2000);
    send_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(3'd7, 32'd0, 32'd0, 32'd0);

    // Bad pool sizes are refused and leave the block not ready.
    write_pool_size(32'd0);
    send_request(bfsa_pkg::KIND_INIT, 32'd0, 32'd0, 32'd0);
    write_pool_size(32'hFFFF_FFFF);
    send_request(bfsa_pkg::KIND_INIT, 32'd0, 32'd0, 32'd0);
    write_pool_size(32'h8000_0001);
    send_request(bfsa_pkg::KIND_INIT, 32'd0, 32'd0, 32'd0);

    // Pool no bigger than the sentinel: nothing free, so allocate cannot fit.
    write_pool_size(32'd100);
    send_request(bfsa_pkg::KIND_INIT, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'd1, 32'd1, 32'd0);
    send_request(bfsa_pkg::KIND_PURGE, 32'd0, 32'd0, 32'd0);

    // Largest legal pool: zero arguments, odd and huge alignments, mark/purge/free.
    write_pool_size(32'h8000_0000);
    send_request(bfsa_pkg::KIND_INIT, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'd1, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'h100, 32'd3, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'h10, 32'h8000_0000, 32'd0);
    send_request(bfsa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 32'd1, 32'd0);
    send_request(bfsa_pkg::KIND_FREE, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_FREE, 32'd0, 32'd0, 32'h1234_5678);
    send_request(bfsa_pkg::KIND_MARK, 32'd0, 32'd0, 32'h1000);
    send_request(bfsa_pkg::KIND_PURGE, 32'd0, 32'd0, 32'd0);
    send_request(bfsa_pkg::KIND_FREE, 32'd0, 32'd0, 32'h1000);
    send_request(3'd6, 32'd0, 32'd0, 32'd0);

    // Random phases: each sets a pool size and an idling pattern.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 16; rx_stall_pct = 16; end
      endcase
      write_pool_size(p == 7 ? $urandom_range(1, 32'h8000_0000) : pools[p % 5]);
      send_request(bfsa_pkg::KIND_INIT, $urandom, $urandom, $urandom);
      for (int n = 0; n < 160; n++) begin
        if (p == 1 && n == 40) hold_request = 3000;  // input backs up behind a held result
        if (p == 1 && n == 80) wait_drained();       // sender waits for every response
        // phases 2 and 5 allocate heavily so the table overflows and drops entries
        random_request((p == 2 || p == 5) ? 85 : 45);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_model.mismatches == 0 && table_model.expected_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit: ~1300 transactions at their worst length plus stalls, taken several times.
  initial begin
    #150ms;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bfsa_pkg.sv
rtl/best_fit_segment_allocator.sv
tb/best_fit_segment_allocator_test.sv
